/* src/modexp_pkg.sv */
// Package for the modular exponentiation block.
// Holds the controller state type and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package modexp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MULP,
    ST_SHIFT,
    ST_MULS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic start_mul;
    logic mul_sq;
    logic step;
    logic wr_power;
    logic wr_prod;
    logic shift_exp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic exp_zero;
    logic exp_lsb;
    logic exp_hi_zero;
    logic mod_zero;
    logic out_busy;
  } status_t;

endpackage

/* src/modexp_if.sv */
// Request channel interfaces of the modular exponentiation block.
// Input channel carries base and exponent, output channel the result.
// No dependencies.
`timescale 1ns / 1ps

interface modexp_in_if #(parameter int WIDTH = 32);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base_value;
  logic [WIDTH-1:0] exponent;

  modport source (output valid, base_value, exponent, input ready);
  modport sink (input valid, base_value, exponent, output ready);
endinterface

interface modexp_out_if #(parameter int WIDTH = 32);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power_result;
  logic             bad_modulus;

  modport source (output valid, power_result, bad_modulus, input ready);
  modport sink (input valid, power_result, bad_modulus, output ready);
endinterface

/* src/modular_exponentiation.sv */
// Top level of the modular exponentiation block.
// Instantiates modexp_ctrl and modexp_dp and holds the modulus register.
// Depends on modexp_pkg and the channel interfaces in modexp_if.
//
//   channel   direction  contents
//   in_chan   sink       base_value, exponent
//   out_chan  source     power_result, bad_modulus
//   psel...   APB slave  modulus register at address 0
//
// The base is first reduced; then, for each exponent bit up to the top set bit, a set
// bit costs a multiply and every bit but the top one a squaring, all on the bit-serial
// multiplier. The result register then loads from the done state. With a zero modulus
// the controller goes from idle straight to the done state. Reset is synchronous and
// clears the modulus and the output valid flag, but not the result register.
// A new request is taken while a result waits in the output register; the controller
// stalls only to load a result.
`timescale 1ns / 1ps

module modular_exponentiation #(
  parameter int WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  modexp_in_if.sink                              in_chan,
  modexp_out_if.source                           out_chan,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [((WIDTH > 32) ? 4 : 3)-1:0]      paddr,
  input  logic [((WIDTH > 32) ? 64 : 32)-1:0]    pwdata,
  output logic [((WIDTH > 32) ? 64 : 32)-1:0]    prdata,
  output logic                                   pready
);

  localparam int CFG_AW = (WIDTH > 32) ? 4 : 3;
  localparam int CFG_DW = (WIDTH > 32) ? 64 : 32;

  logic [WIDTH-1:0]    mod_r;
  logic                reg_hit;
  modexp_pkg::cmd_t    cmd;
  modexp_pkg::status_t st;
  logic                in_ready;

  assign reg_hit = (paddr[CFG_AW-1] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? CFG_DW'(mod_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      mod_r <= pwdata[WIDTH-1:0];
    end
  end

  modexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  modexp_dp #(.WIDTH(WIDTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .mod_i        (mod_r),
    .base_i       (in_chan.base_value),
    .exp_i        (in_chan.exponent),
    .out_ready_i  (out_chan.ready),
    .out_valid_o  (out_chan.valid),
    .out_result_o (out_chan.power_result),
    .out_bad_o    (out_chan.bad_modulus)
  );

  assign in_chan.ready = in_ready;

endmodule

/* src/modexp_ctrl.sv */
// Controller of the modular exponentiation block.
// Sequences base reduction, multiplies and squarings; uses modexp_pkg.
`timescale 1ns / 1ps

module modexp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  modexp_pkg::status_t st,
  output modexp_pkg::cmd_t    cmd
);

  modexp_pkg::state_t state_r;
  modexp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= modexp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      modexp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = st.mod_zero ? modexp_pkg::ST_DONE : modexp_pkg::ST_REDUCE;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        cmd.step = 1'b1;
        if (st.cnt_last) begin
          cmd.wr_power = 1'b1;
          state_nxt    = modexp_pkg::ST_CHECK;
        end
      end
      modexp_pkg::ST_CHECK: begin
        if (st.exp_zero) begin
          state_nxt = modexp_pkg::ST_DONE;
        end else if (st.exp_lsb) begin
          cmd.start_mul = 1'b1;
          state_nxt     = modexp_pkg::ST_MULP;
        end else begin
          state_nxt = modexp_pkg::ST_SHIFT;
        end
      end
      modexp_pkg::ST_MULP: begin
        cmd.step = 1'b1;
        if (st.cnt_last) begin
          cmd.wr_prod = 1'b1;
          state_nxt   = modexp_pkg::ST_SHIFT;
        end
      end
      modexp_pkg::ST_SHIFT: begin
        cmd.shift_exp = 1'b1;
        if (!st.exp_hi_zero) begin
          cmd.start_mul = 1'b1;
          cmd.mul_sq    = 1'b1;
          state_nxt     = modexp_pkg::ST_MULS;
        end else begin
          state_nxt = modexp_pkg::ST_DONE;
        end
      end
      modexp_pkg::ST_MULS: begin
        cmd.step = 1'b1;
        if (st.cnt_last) begin
          cmd.wr_power = 1'b1;
          state_nxt    = modexp_pkg::ST_CHECK;
        end
      end
      modexp_pkg::ST_DONE: begin
        if (!st.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = modexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = modexp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/modexp_dp.sv */
// Datapath of the modular exponentiation block.
// Holds the operands, the bit-serial modular multiplier and the result register.
// Uses modexp_pkg for the command and status structs.
`timescale 1ns / 1ps

module modexp_dp #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  modexp_pkg::cmd_t    cmd,
  output modexp_pkg::status_t st,
  input  logic [WIDTH-1:0]    mod_i,
  input  logic [WIDTH-1:0]    base_i,
  input  logic [WIDTH-1:0]    exp_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [WIDTH-1:0]    out_result_o,
  output logic                out_bad_o
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] opa_r, opb_r;
  logic [WIDTH-1:0] power_r, prod_r, exp_r;
  logic [CW-1:0]    cnt_r;
  logic             out_valid_r;
  logic [WIDTH-1:0] result_r;
  logic             bad_r;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] mod1;
  logic [WIDTH+1:0] mod2;

  // One bit of the multiplier per cycle while the step command is set: acc = (2*acc + bit*a) mod m.
  always_comb begin
    mod1 = {2'b00, mod_i};
    mod2 = {1'b0, mod_i, 1'b0};
    sum  = {1'b0, acc_r, 1'b0} + (opb_r[WIDTH-1] ? {2'b00, opa_r} : '0);
    if (sum >= mod2) begin
      acc_nxt = WIDTH'(sum - mod2);
    end else if (sum >= mod1) begin
      acc_nxt = WIDTH'(sum - mod1);
    end else begin
      acc_nxt = sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r  <= '0;
      opa_r  <= WIDTH'(1);
      opb_r  <= base_i;
      cnt_r  <= '0;
      exp_r  <= exp_i;
      prod_r <= (mod_i == WIDTH'(1)) ? '0 : WIDTH'(1);
    end else if (cmd.start_mul) begin
      acc_r <= '0;
      opa_r <= cmd.mul_sq ? power_r : prod_r;
      opb_r <= power_r;
      cnt_r <= '0;
    end else if (cmd.step) begin
      acc_r <= acc_nxt;
      opb_r <= {opb_r[WIDTH-2:0], 1'b0};
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.wr_power) begin
      power_r <= acc_nxt;
    end
    if (cmd.wr_prod) begin
      prod_r <= acc_nxt;
    end
    if (cmd.shift_exp) begin
      exp_r <= {1'b0, exp_r[WIDTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bad_r    <= (mod_i == '0);
      result_r <= (mod_i == '0) ? '0 : prod_r;
    end
  end

  assign st.cnt_last    = (cnt_r == CW'(WIDTH - 1));
  assign st.exp_zero    = (exp_r == '0);
  assign st.exp_lsb     = exp_r[0];
  assign st.exp_hi_zero = (exp_r[WIDTH-1:1] == '0);
  assign st.mod_zero    = (mod_i == '0);
  assign st.out_busy    = out_valid_r && !out_ready_i;

  assign out_valid_o  = out_valid_r;
  assign out_result_o = result_r;
  assign out_bad_o    = bad_r;

`ifndef SYNTHESIS
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.step) && (mod_i != '0) |-> acc_r < mod_i)
    else $error("Accumulator left unreduced after a multiplier step.");

  a_prod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.wr_prod) || $past(cmd.load)) && (mod_i != '0) |-> prod_r < mod_i)
    else $error("Running product is not below the modulus.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready_i |-> !cmd.emit)
    else $error("A held result was overwritten.");
`endif

endmodule

/* bench/modular_exponentiation_tb.sv */
// Self-checking testbench for modular_exponentiation: drives base/exponent requests,
// programs the modulus over APB, and checks every result against a built-in predictor.
// Depends on src/modexp_pkg.sv, src/modexp_if.sv and src/modular_exponentiation.sv.
`timescale 1ns / 1ps

module modular_exponentiation_tb;

  localparam int WIDTH = 32;
  localparam logic [2:0] ADDR_MODULUS = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
  localparam int DRAIN_CYCLES = 2200;
  localparam int HOLD_OFF_CYCLES = 8000;

  typedef struct packed {
    logic [WIDTH-1:0] base_value;
    logic [WIDTH-1:0] exponent;
  } power_req_t;

  typedef struct packed {
    logic [WIDTH-1:0] power_result;
    logic             bad_modulus;
  } power_rsp_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  modexp_in_if #(.WIDTH(WIDTH)) in_if ();
  modexp_out_if #(.WIDTH(WIDTH)) out_if ();

  modular_exponentiation #(.WIDTH(WIDTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  power_req_t       pending_reqs[$];
  power_rsp_t       expected_rsps[$];
  logic [WIDTH-1:0] modulus_copy;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               mismatches;
  int               rsp_count;
  bit               req_taken;
  bit               rx_hold;
  bit               pressure_go;

  function automatic power_rsp_t predict_power(input logic [WIDTH-1:0] base_in,
                                               input logic [WIDTH-1:0] exp_in,
                                               input logic [WIDTH-1:0] modulus);
    power_rsp_t         rsp;
    logic [2*WIDTH-1:0] m;
    logic [2*WIDTH-1:0] sq;
    logic [2*WIDTH-1:0] acc;
    logic [WIDTH-1:0]   e;
    rsp = '0;
    if (modulus == '0) begin
      rsp.bad_modulus = 1'b1;
      return rsp;
    end
    m = {{WIDTH{1'b0}}, modulus};
    sq = {{WIDTH{1'b0}}, base_in} % m;
    acc = (2*WIDTH)'(1) % m;
    e = exp_in;
    while (e != '0) begin
      if (e[0]) begin
        acc = (acc * sq) % m;
      end
      e = e >> 1;
      if (e != '0) begin
        sq = (sq * sq) % m;
      end
    end
    rsp.power_result = acc[WIDTH-1:0];
    return rsp;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("modular_exponentiation: mismatch");
    $finish;
  end

  // Request driver: a request is held until it is accepted.
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || req_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.base_value <= pending_reqs[0].base_value;
        in_if.exponent <= pending_reqs[0].exponent;
        void'(pending_reqs.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    wait (pressure_go);
    rx_hold = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin
    power_rsp_t want;
    if (rst_n) begin
      req_taken = in_if.valid && in_if.ready;
      if (req_taken) begin
        expected_rsps = {expected_rsps, predict_power(in_if.base_value, in_if.exponent,
                                                      modulus_copy)};
      end
      if (out_if.valid && out_if.ready) begin
        rsp_count++;
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    rsp_count));
        end else begin
          want = expected_rsps.pop_front();
          if (out_if.power_result !== want.power_result ||
              out_if.bad_modulus !== want.bad_modulus) begin
            report_mismatch($sformatf("result %0d: expected %h bad=%b, got %h bad=%b",
                                      rsp_count, want.power_result, want.bad_modulus,
                                      out_if.power_result, out_if.bad_modulus));
          end
        end
      end
    end
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MODULUS) begin
      modulus_copy = data;
    end
  endtask

  task automatic check_modulus();
    logic [31:0] value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_MODULUS;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (value !== modulus_copy) begin
      report_mismatch($sformatf("modulus read back %h, expected %h", value, modulus_copy));
    end
  endtask

  task automatic set_modulus(input logic [31:0] value);
    cfg_write(ADDR_MODULUS, value);
    check_modulus();
  endtask

  task automatic queue_req(input logic [WIDTH-1:0] base_in, input logic [WIDTH-1:0] exp_in);
    power_req_t r;
    r.base_value = base_in;
    r.exponent = exp_in;
    pending_reqs = {pending_reqs, r};
  endtask

  // Exponents are mostly short so that the long full-width ones stay affordable.
  task automatic queue_random(input int count);
    power_req_t r;
    int         pick;
    repeat (count) begin
      case ($urandom_range(9))
        0: r.base_value = '0;
        1: r.base_value = '1;
        2: r.base_value = modulus_copy + $urandom_range(2) - 1;
        default: r.base_value = $urandom;
      endcase
      pick = $urandom_range(99);
      if (pick < 10) begin
        r.exponent = $urandom_range(1);
      end else if (pick < 75) begin
        r.exponent = $urandom & ((32'd1 << $urandom_range(12)) - 32'd1);
      end else begin
        r.exponent = $urandom;
      end
      pending_reqs = {pending_reqs, r};
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || expected_rsps.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.base_value = '0;
    in_if.exponent = '0;
    out_if.ready = 1'b0;
    modulus_copy = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The modulus still holds its reset value of zero.
    queue_req('0, '0);
    queue_req('1, '1);
    queue_req(32'd5, 32'd3);
    wait_idle();

    set_modulus(32'd1);
    queue_req('1, '0);
    queue_req(32'd7, 32'd5);
    wait_idle();

    // A write to an unmapped register must leave the modulus alone.
    set_modulus(32'd13);
    cfg_write(ADDR_UNMAPPED, 32'd7);
    check_modulus();
    queue_req('0, '0);
    queue_req('0, 32'd5);
    queue_req(32'd1, '1);
    queue_req(32'd12, 32'd2);
    queue_req('1, 32'd1);
    queue_req(32'd3, '0);
    queue_req(32'd2, 32'd12);
    queue_req(32'd13, 32'd6);
    wait_idle();

    set_modulus('1);
    queue_req('1, '1);
    queue_req(32'hFFFF_FFFE, 32'd2);
    queue_req(32'd2, 32'd31);
    queue_req(32'h8000_0000, 32'd2);
    queue_req(32'h1234_5678, 32'h8000_0000);
    wait_idle();

    set_modulus(32'h8000_0000);
    queue_req(32'd3, 32'd31);
    queue_req(32'h7FFF_FFFF, 32'd2);
    queue_req('1, 32'd3);
    wait_idle();

    tx_idle_pct = 24;
    rx_idle_pct = 84;
    set_modulus($urandom);
    queue_random(50);
    wait_idle();
    set_modulus($urandom_range(1000, 2));
    queue_random(45);
    wait_idle();

    tx_idle_pct = 84;
    rx_idle_pct = 24;
    set_modulus($urandom | 32'h8000_0001);
    queue_random(50);
    wait_idle();
    set_modulus($urandom_range(3));
    queue_random(20);
    wait_idle();

    // Receiver holds off while requests keep coming, so the input backs up.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_modulus($urandom);
    pressure_go = 1'b1;
    queue_random(60);
    wait_idle();
    set_modulus($urandom >> $urandom_range(31));
    queue_random(55);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("modular_exponentiation: match");
    end else begin
      $display("modular_exponentiation: mismatch");
    end
    $finish;
  end

endmodule
